/* design/sgpm_pkg.sv */
// Package for the stereo gain, balance ramp and peak meter block.
// Holds the widths, constants, register indexes, state type and the
// command and status structs shared by the controller and datapath.
package sgpm_pkg;

    localparam int SAMPLE_BITS    = 24;
    localparam int GAIN_FRAC_BITS = 16;
    localparam int ACC_EXTRA      = 16;
    localparam int MAX_BLOCK      = 4096;
    localparam int PEAK_FLOOR     = 9;

    localparam int LEN_W      = $clog2(MAX_BLOCK) + 1;
    localparam int IDX_W      = $clog2(MAX_BLOCK);
    localparam int VOL_W      = 18;
    localparam int PAN_W      = 16;
    localparam int FACT_W     = PAN_W - 1;
    localparam int DECAY_W    = 16;
    localparam int METER_W    = SAMPLE_BITS - 1;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_ADDR_W = 1;

    // The running gain may overshoot its end value when the block length
    // grows mid-block, so the accumulator keeps room for a full block of it.
    localparam int ACC_W      = 48;
    localparam int STEP_W     = 36;
    localparam int DIFF_W     = VOL_W + 1;
    localparam int QUO_W      = VOL_W + ACC_EXTRA;
    localparam int GAIN_MUL_W = ACC_W - ACC_EXTRA;
    localparam int PROD_W     = SAMPLE_BITS + GAIN_MUL_W + 1;
    localparam int SHIFT_W    = PROD_W - GAIN_FRAC_BITS;
    localparam int CNT_W      = $clog2(QUO_W + 1);

    localparam int NUM_PEAKS = 4;
    localparam int SEL_W     = $clog2(NUM_PEAKS);
    localparam logic [SEL_W-1:0] SEL_LAST = SEL_W'(NUM_PEAKS - 1);

    // Peak meter slots.
    localparam logic [SEL_W-1:0] PK_IN_L  = 2'd0;
    localparam logic [SEL_W-1:0] PK_IN_R  = 2'd1;
    localparam logic [SEL_W-1:0] PK_OUT_L = 2'd2;
    localparam logic [SEL_W-1:0] PK_OUT_R = 2'd3;

    // Gain slots: start gains from the last target, end gains from the new one.
    localparam logic [SEL_W-1:0] G_START_L = 2'd0;
    localparam logic [SEL_W-1:0] G_START_R = 2'd1;
    localparam logic [SEL_W-1:0] G_END_L   = 2'd2;
    localparam logic [SEL_W-1:0] G_END_R   = 2'd3;

    localparam logic [CFG_ADDR_W-1:0] CFG_FRAMES_PER_BLOCK = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_PEAK_DECAY       = 1'b1;

    localparam logic FUNC_SET_TARGET = 1'b0;
    localparam logic FUNC_FRAME      = 1'b1;

    localparam logic [LEN_W-1:0]   FPB_RESET   = LEN_W'(256);
    localparam logic [DECAY_W-1:0] DECAY_RESET = DECAY_W'(63039);
    localparam logic [VOL_W-1:0]   UNITY_GAIN  = VOL_W'(64'd1 << GAIN_FRAC_BITS);
    localparam logic signed [PAN_W:0] PAN_ONE  = (PAN_W+1)'(64'd1 << FACT_W);

    localparam logic signed [SHIFT_W-1:0] SAT_HI =
        SHIFT_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [SHIFT_W-1:0] SAT_LO = -SAT_HI - SHIFT_W'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECAY,
        ST_GAIN,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_MUL,
        ST_UPDATE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic             accept;
        logic             decay_en;
        logic             gain_en;
        logic [SEL_W-1:0] sel;
        logic             div_start;
        logic             step_load;
        logic             mul_en;
        logic             update_en;
        logic             out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic new_block;
        logic div_done;
    } dp_stat_t;

endpackage

/* design/sgpm_div.sv */
// Restoring divider, one quotient bit per cycle, for the gain ramp step.
// Uses sgpm_pkg for its widths.
module sgpm_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [sgpm_pkg::QUO_W-1:0]   dividend,
    input  logic [sgpm_pkg::LEN_W-1:0]   divisor,
    output logic                         busy,
    output logic [sgpm_pkg::QUO_W-1:0]   quotient
);

    logic                          busy_reg;
    logic [sgpm_pkg::CNT_W-1:0]    cnt_reg;
    logic [sgpm_pkg::QUO_W-1:0]    quo_reg;
    logic [sgpm_pkg::QUO_W-1:0]    quo_next;
    logic [sgpm_pkg::LEN_W-1:0]    rem_reg;
    logic [sgpm_pkg::LEN_W-1:0]    rem_next;
    logic [sgpm_pkg::LEN_W-1:0]    dsr_reg;
    logic [sgpm_pkg::LEN_W:0]      rem_sh;
    logic [sgpm_pkg::LEN_W:0]      rem_sub;
    logic                          fits;

    // The dividend shifts out of the top of quo_reg while quotient bits enter at the bottom.
    always_comb begin
        rem_sh   = {rem_reg, quo_reg[sgpm_pkg::QUO_W-1]};
        rem_sub  = rem_sh - {1'b0, dsr_reg};
        fits     = (rem_sh >= {1'b0, dsr_reg});
        rem_next = fits ? rem_sub[sgpm_pkg::LEN_W-1:0] : rem_sh[sgpm_pkg::LEN_W-1:0];
        quo_next = {quo_reg[sgpm_pkg::QUO_W-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= sgpm_pkg::CNT_W'(sgpm_pkg::QUO_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - sgpm_pkg::CNT_W'(1);
            if (cnt_reg == sgpm_pkg::CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

/* design/sgpm_dp.sv */
// Datapath of the gain, balance ramp and peak meter block: configuration,
// target and ramp state, peak meters, multipliers and two step dividers.
// Uses sgpm_pkg and instantiates sgpm_div.
module sgpm_dp (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  sgpm_pkg::ctrl_cmd_t                     cmd,
    output sgpm_pkg::dp_stat_t                      stat,
    input  logic                                    cfg_wr_en,
    input  logic [sgpm_pkg::CFG_ADDR_W-1:0]         cfg_addr,
    input  logic [sgpm_pkg::CFG_DATA_W-1:0]         cfg_wdata,
    input  logic                                    s_func,
    input  logic [sgpm_pkg::VOL_W-1:0]              s_volume_gain,
    input  logic signed [sgpm_pkg::PAN_W-1:0]       s_pan,
    input  logic                                    s_input_present,
    input  logic signed [sgpm_pkg::SAMPLE_BITS-1:0] s_sample_left,
    input  logic signed [sgpm_pkg::SAMPLE_BITS-1:0] s_sample_right,
    output logic signed [sgpm_pkg::SAMPLE_BITS-1:0] m_out_left,
    output logic signed [sgpm_pkg::SAMPLE_BITS-1:0] m_out_right,
    output logic [sgpm_pkg::METER_W-1:0]            m_meter_in_left,
    output logic [sgpm_pkg::METER_W-1:0]            m_meter_in_right,
    output logic [sgpm_pkg::METER_W-1:0]            m_meter_out_left,
    output logic [sgpm_pkg::METER_W-1:0]            m_meter_out_right
);

    // Configuration.
    logic [sgpm_pkg::LEN_W-1:0]   fpb_reg;
    logic [sgpm_pkg::DECAY_W-1:0] decay_reg;

    // Targets and ramp state.
    logic [sgpm_pkg::VOL_W-1:0]         tgt_vol_reg;
    logic signed [sgpm_pkg::PAN_W-1:0]  tgt_bal_reg;
    logic [sgpm_pkg::VOL_W-1:0]         last_vol_reg;
    logic signed [sgpm_pkg::PAN_W-1:0]  last_bal_reg;
    logic [sgpm_pkg::ACC_W-1:0]         acc_l_reg;
    logic [sgpm_pkg::ACC_W-1:0]         acc_r_reg;
    logic signed [sgpm_pkg::STEP_W-1:0] step_l_reg;
    logic signed [sgpm_pkg::STEP_W-1:0] step_r_reg;
    logic [sgpm_pkg::IDX_W-1:0]         idx_reg;
    logic [sgpm_pkg::METER_W-1:0]       peak_reg [sgpm_pkg::NUM_PEAKS];

    // Per-request working registers.
    logic                                    present_reg;
    logic signed [sgpm_pkg::SAMPLE_BITS-1:0] smp_l_reg;
    logic signed [sgpm_pkg::SAMPLE_BITS-1:0] smp_r_reg;
    logic [sgpm_pkg::VOL_W-1:0]              gain_reg [sgpm_pkg::NUM_PEAKS];
    logic                                    sign_l_reg;
    logic                                    sign_r_reg;
    logic signed [sgpm_pkg::PROD_W-1:0]      prod_l_reg;
    logic signed [sgpm_pkg::PROD_W-1:0]      prod_r_reg;
    logic signed [sgpm_pkg::SAMPLE_BITS-1:0] res_l_reg;
    logic signed [sgpm_pkg::SAMPLE_BITS-1:0] res_r_reg;

    // Output payload.
    logic signed [sgpm_pkg::SAMPLE_BITS-1:0] out_l_reg;
    logic signed [sgpm_pkg::SAMPLE_BITS-1:0] out_r_reg;
    logic [sgpm_pkg::METER_W-1:0]            mtr_reg [sgpm_pkg::NUM_PEAKS];

    // Block length and frame position.
    logic [sgpm_pkg::LEN_W-1:0] len;
    logic                       new_block;
    logic [sgpm_pkg::IDX_W-1:0] idx_eff;
    logic [sgpm_pkg::LEN_W-1:0] idx_inc;
    logic [sgpm_pkg::IDX_W-1:0] idx_next;

    always_comb begin
        if (fpb_reg == '0) begin
            len = sgpm_pkg::LEN_W'(1);
        end else if (fpb_reg > sgpm_pkg::LEN_W'(sgpm_pkg::MAX_BLOCK)) begin
            len = sgpm_pkg::LEN_W'(sgpm_pkg::MAX_BLOCK);
        end else begin
            len = fpb_reg;
        end
        new_block = (idx_reg == '0) || ({1'b0, idx_reg} >= len);
        idx_eff   = new_block ? '0 : idx_reg;
        idx_inc   = {1'b0, idx_eff} + sgpm_pkg::LEN_W'(1);
        idx_next  = (idx_inc >= len) ? '0 : idx_inc[sgpm_pkg::IDX_W-1:0];
    end

    // Peak decay: one meter per cycle through one multiplier.
    logic [sgpm_pkg::METER_W+sgpm_pkg::DECAY_W-1:0] dprod;
    logic [sgpm_pkg::METER_W-1:0]                   decayed;

    always_comb begin
        dprod   = {{sgpm_pkg::DECAY_W{1'b0}}, peak_reg[cmd.sel]}
                * {{sgpm_pkg::METER_W{1'b0}}, decay_reg};
        decayed = dprod[sgpm_pkg::DECAY_W +: sgpm_pkg::METER_W];
    end

    // Balance-scaled channel gain: one of the four gains per cycle.
    logic [sgpm_pkg::VOL_W-1:0]                   vol_sel;
    logic signed [sgpm_pkg::PAN_W-1:0]            bal_sel;
    logic                                         is_right;
    logic                                         scale;
    logic signed [sgpm_pkg::PAN_W:0]              fact_ext;
    logic [sgpm_pkg::VOL_W+sgpm_pkg::FACT_W-1:0]  gprod;
    logic [sgpm_pkg::VOL_W-1:0]                   gain_val;

    always_comb begin
        vol_sel  = cmd.sel[1] ? tgt_vol_reg : last_vol_reg;
        bal_sel  = cmd.sel[1] ? tgt_bal_reg : last_bal_reg;
        is_right = cmd.sel[0];
        if (is_right) begin
            scale    = bal_sel[sgpm_pkg::PAN_W-1];
            fact_ext = sgpm_pkg::PAN_ONE + (sgpm_pkg::PAN_W+1)'(bal_sel);
        end else begin
            scale    = !bal_sel[sgpm_pkg::PAN_W-1] && (bal_sel != '0);
            fact_ext = sgpm_pkg::PAN_ONE - (sgpm_pkg::PAN_W+1)'(bal_sel);
        end
        gprod    = {{sgpm_pkg::FACT_W{1'b0}}, vol_sel}
                 * {{sgpm_pkg::VOL_W{1'b0}}, fact_ext[sgpm_pkg::FACT_W-1:0]};
        gain_val = scale ? gprod[sgpm_pkg::FACT_W +: sgpm_pkg::VOL_W] : vol_sel;
    end

    // Step dividers: |end - start| * 2^16 / len, sign applied afterwards.
    logic signed [sgpm_pkg::DIFF_W-1:0] diff_l;
    logic signed [sgpm_pkg::DIFF_W-1:0] diff_r;
    logic signed [sgpm_pkg::DIFF_W-1:0] mag_l;
    logic signed [sgpm_pkg::DIFF_W-1:0] mag_r;
    logic [sgpm_pkg::QUO_W-1:0]         dvd_l;
    logic [sgpm_pkg::QUO_W-1:0]         dvd_r;
    logic [sgpm_pkg::QUO_W-1:0]         quo_l;
    logic [sgpm_pkg::QUO_W-1:0]         quo_r;
    logic                               busy_l;
    logic                               busy_r;
    logic signed [sgpm_pkg::STEP_W-1:0] qext_l;
    logic signed [sgpm_pkg::STEP_W-1:0] qext_r;

    always_comb begin
        diff_l = $signed({1'b0, gain_reg[sgpm_pkg::G_END_L]})
               - $signed({1'b0, gain_reg[sgpm_pkg::G_START_L]});
        diff_r = $signed({1'b0, gain_reg[sgpm_pkg::G_END_R]})
               - $signed({1'b0, gain_reg[sgpm_pkg::G_START_R]});
        mag_l  = diff_l[sgpm_pkg::DIFF_W-1] ? -diff_l : diff_l;
        mag_r  = diff_r[sgpm_pkg::DIFF_W-1] ? -diff_r : diff_r;
        dvd_l  = {mag_l[sgpm_pkg::VOL_W-1:0], {sgpm_pkg::ACC_EXTRA{1'b0}}};
        dvd_r  = {mag_r[sgpm_pkg::VOL_W-1:0], {sgpm_pkg::ACC_EXTRA{1'b0}}};
        qext_l = $signed({{(sgpm_pkg::STEP_W-sgpm_pkg::QUO_W){1'b0}}, quo_l});
        qext_r = $signed({{(sgpm_pkg::STEP_W-sgpm_pkg::QUO_W){1'b0}}, quo_r});
    end

    sgpm_div u_div_l (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (dvd_l),
        .divisor  (len),
        .busy     (busy_l),
        .quotient (quo_l)
    );

    sgpm_div u_div_r (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (dvd_r),
        .divisor  (len),
        .busy     (busy_r),
        .quotient (quo_r)
    );

    // Output rounding (floor), saturation and gain accumulation.
    logic signed [sgpm_pkg::SHIFT_W-1:0]     shl_l;
    logic signed [sgpm_pkg::SHIFT_W-1:0]     shl_r;
    logic signed [sgpm_pkg::SAMPLE_BITS-1:0] sat_l;
    logic signed [sgpm_pkg::SAMPLE_BITS-1:0] sat_r;
    logic signed [sgpm_pkg::ACC_W:0]         acc_sum_l;
    logic signed [sgpm_pkg::ACC_W:0]         acc_sum_r;
    logic [sgpm_pkg::ACC_W-1:0]              acc_l_next;
    logic [sgpm_pkg::ACC_W-1:0]              acc_r_next;

    always_comb begin
        shl_l = sgpm_pkg::SHIFT_W'(prod_l_reg >>> sgpm_pkg::GAIN_FRAC_BITS);
        shl_r = sgpm_pkg::SHIFT_W'(prod_r_reg >>> sgpm_pkg::GAIN_FRAC_BITS);
        if (shl_l > sgpm_pkg::SAT_HI) begin
            sat_l = sgpm_pkg::SAT_HI[sgpm_pkg::SAMPLE_BITS-1:0];
        end else if (shl_l < sgpm_pkg::SAT_LO) begin
            sat_l = sgpm_pkg::SAT_LO[sgpm_pkg::SAMPLE_BITS-1:0];
        end else begin
            sat_l = shl_l[sgpm_pkg::SAMPLE_BITS-1:0];
        end
        if (shl_r > sgpm_pkg::SAT_HI) begin
            sat_r = sgpm_pkg::SAT_HI[sgpm_pkg::SAMPLE_BITS-1:0];
        end else if (shl_r < sgpm_pkg::SAT_LO) begin
            sat_r = sgpm_pkg::SAT_LO[sgpm_pkg::SAMPLE_BITS-1:0];
        end else begin
            sat_r = shl_r[sgpm_pkg::SAMPLE_BITS-1:0];
        end
        acc_sum_l  = $signed({1'b0, acc_l_reg}) + (sgpm_pkg::ACC_W+1)'(step_l_reg);
        acc_sum_r  = $signed({1'b0, acc_r_reg}) + (sgpm_pkg::ACC_W+1)'(step_r_reg);
        acc_l_next = acc_sum_l[sgpm_pkg::ACC_W] ? '0 : acc_sum_l[sgpm_pkg::ACC_W-1:0];
        acc_r_next = acc_sum_r[sgpm_pkg::ACC_W] ? '0 : acc_sum_r[sgpm_pkg::ACC_W-1:0];
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fpb_reg   <= sgpm_pkg::FPB_RESET;
            decay_reg <= sgpm_pkg::DECAY_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                sgpm_pkg::CFG_FRAMES_PER_BLOCK: begin
                    fpb_reg <= cfg_wdata[sgpm_pkg::LEN_W-1:0];
                end
                sgpm_pkg::CFG_PEAK_DECAY: begin
                    decay_reg <= cfg_wdata[sgpm_pkg::DECAY_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Ramp, target and meter state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tgt_vol_reg  <= sgpm_pkg::UNITY_GAIN;
            tgt_bal_reg  <= '0;
            last_vol_reg <= sgpm_pkg::UNITY_GAIN;
            last_bal_reg <= '0;
            acc_l_reg    <= '0;
            acc_r_reg    <= '0;
            step_l_reg   <= '0;
            step_r_reg   <= '0;
            idx_reg      <= '0;
            for (int i = 0; i < sgpm_pkg::NUM_PEAKS; i++) begin
                peak_reg[i] <= '0;
            end
        end else begin
            if (cmd.accept && (s_func == sgpm_pkg::FUNC_SET_TARGET)) begin
                tgt_vol_reg <= s_volume_gain;
                tgt_bal_reg <= s_pan;
            end
            if (cmd.decay_en) begin
                peak_reg[cmd.sel] <= (decayed < sgpm_pkg::METER_W'(sgpm_pkg::PEAK_FLOOR))
                                   ? '0 : decayed;
            end
            if (cmd.div_start) begin
                acc_l_reg    <= sgpm_pkg::ACC_W'({gain_reg[sgpm_pkg::G_START_L],
                                                   {sgpm_pkg::ACC_EXTRA{1'b0}}});
                acc_r_reg    <= sgpm_pkg::ACC_W'({gain_reg[sgpm_pkg::G_START_R],
                                                   {sgpm_pkg::ACC_EXTRA{1'b0}}});
                last_vol_reg <= tgt_vol_reg;
                last_bal_reg <= tgt_bal_reg;
            end
            if (cmd.step_load) begin
                step_l_reg <= sign_l_reg ? -qext_l : qext_l;
                step_r_reg <= sign_r_reg ? -qext_r : qext_r;
            end
            if (cmd.update_en) begin
                acc_l_reg <= acc_l_next;
                acc_r_reg <= acc_r_next;
                idx_reg   <= idx_next;
                if (present_reg) begin
                    // Only positive values can raise a meter.
                    if (!smp_l_reg[sgpm_pkg::SAMPLE_BITS-1]
                        && (smp_l_reg[sgpm_pkg::METER_W-1:0] > peak_reg[sgpm_pkg::PK_IN_L])) begin
                        peak_reg[sgpm_pkg::PK_IN_L] <= smp_l_reg[sgpm_pkg::METER_W-1:0];
                    end
                    if (!smp_r_reg[sgpm_pkg::SAMPLE_BITS-1]
                        && (smp_r_reg[sgpm_pkg::METER_W-1:0] > peak_reg[sgpm_pkg::PK_IN_R])) begin
                        peak_reg[sgpm_pkg::PK_IN_R] <= smp_r_reg[sgpm_pkg::METER_W-1:0];
                    end
                    if (!sat_l[sgpm_pkg::SAMPLE_BITS-1]
                        && (sat_l[sgpm_pkg::METER_W-1:0] > peak_reg[sgpm_pkg::PK_OUT_L])) begin
                        peak_reg[sgpm_pkg::PK_OUT_L] <= sat_l[sgpm_pkg::METER_W-1:0];
                    end
                    if (!sat_r[sgpm_pkg::SAMPLE_BITS-1]
                        && (sat_r[sgpm_pkg::METER_W-1:0] > peak_reg[sgpm_pkg::PK_OUT_R])) begin
                        peak_reg[sgpm_pkg::PK_OUT_R] <= sat_r[sgpm_pkg::METER_W-1:0];
                    end
                end
            end
        end
    end

    // Working and payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            present_reg <= s_input_present;
            smp_l_reg   <= s_sample_left;
            smp_r_reg   <= s_sample_right;
            res_l_reg   <= '0;
            res_r_reg   <= '0;
        end
        if (cmd.gain_en) begin
            gain_reg[cmd.sel] <= gain_val;
        end
        if (cmd.div_start) begin
            sign_l_reg <= diff_l[sgpm_pkg::DIFF_W-1];
            sign_r_reg <= diff_r[sgpm_pkg::DIFF_W-1];
        end
        if (cmd.mul_en) begin
            prod_l_reg <= smp_l_reg
                        * $signed({1'b0, acc_l_reg[sgpm_pkg::ACC_W-1 -: sgpm_pkg::GAIN_MUL_W]});
            prod_r_reg <= smp_r_reg
                        * $signed({1'b0, acc_r_reg[sgpm_pkg::ACC_W-1 -: sgpm_pkg::GAIN_MUL_W]});
        end
        if (cmd.update_en && present_reg) begin
            res_l_reg <= sat_l;
            res_r_reg <= sat_r;
        end
        if (cmd.out_load) begin
            out_l_reg <= res_l_reg;
            out_r_reg <= res_r_reg;
            for (int i = 0; i < sgpm_pkg::NUM_PEAKS; i++) begin
                mtr_reg[i] <= peak_reg[i];
            end
        end
    end

    assign stat.new_block = new_block;
    assign stat.div_done  = !busy_l && !busy_r;

    assign m_out_left        = out_l_reg;
    assign m_out_right       = out_r_reg;
    assign m_meter_in_left   = mtr_reg[sgpm_pkg::PK_IN_L];
    assign m_meter_in_right  = mtr_reg[sgpm_pkg::PK_IN_R];
    assign m_meter_out_left  = mtr_reg[sgpm_pkg::PK_OUT_L];
    assign m_meter_out_right = mtr_reg[sgpm_pkg::PK_OUT_R];

endmodule

/* design/sgpm_ctrl.sv */
// Controller state machine of the gain, balance ramp and peak meter block.
// Uses sgpm_pkg for the state type and the command and status structs.
module sgpm_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_func,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  sgpm_pkg::dp_stat_t   stat,
    output sgpm_pkg::ctrl_cmd_t  cmd
);

    sgpm_pkg::state_t              state_reg;
    sgpm_pkg::state_t              state_next;
    logic [sgpm_pkg::SEL_W-1:0]    sel_reg;
    logic [sgpm_pkg::SEL_W-1:0]    sel_next;
    logic                          m_valid_reg;
    logic                          m_valid_next;
    logic                          slot_free;

    assign slot_free = !m_valid_reg || m_ready;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sgpm_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (s_func == sgpm_pkg::FUNC_SET_TARGET) begin
                        state_next = sgpm_pkg::ST_DONE;
                    end else if (stat.new_block) begin
                        state_next = sgpm_pkg::ST_DECAY;
                    end else begin
                        state_next = sgpm_pkg::ST_MUL;
                    end
                end
            end
            sgpm_pkg::ST_DECAY: begin
                if (sel_reg == sgpm_pkg::SEL_LAST) begin
                    state_next = sgpm_pkg::ST_GAIN;
                end
            end
            sgpm_pkg::ST_GAIN: begin
                if (sel_reg == sgpm_pkg::SEL_LAST) begin
                    state_next = sgpm_pkg::ST_DIV_START;
                end
            end
            sgpm_pkg::ST_DIV_START: begin
                state_next = sgpm_pkg::ST_DIV_WAIT;
            end
            sgpm_pkg::ST_DIV_WAIT: begin
                if (stat.div_done) begin
                    state_next = sgpm_pkg::ST_MUL;
                end
            end
            sgpm_pkg::ST_MUL: begin
                state_next = sgpm_pkg::ST_UPDATE;
            end
            sgpm_pkg::ST_UPDATE: begin
                state_next = sgpm_pkg::ST_DONE;
            end
            sgpm_pkg::ST_DONE: begin
                if (slot_free) begin
                    state_next = sgpm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sgpm_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs and commands.
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        cmd.sel = sel_reg;
        case (state_reg)
            sgpm_pkg::ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            sgpm_pkg::ST_DECAY: begin
                cmd.decay_en = 1'b1;
            end
            sgpm_pkg::ST_GAIN: begin
                cmd.gain_en = 1'b1;
            end
            sgpm_pkg::ST_DIV_START: begin
                cmd.div_start = 1'b1;
            end
            sgpm_pkg::ST_DIV_WAIT: begin
                cmd.step_load = stat.div_done;
            end
            sgpm_pkg::ST_MUL: begin
                cmd.mul_en = 1'b1;
            end
            sgpm_pkg::ST_UPDATE: begin
                cmd.update_en = 1'b1;
            end
            sgpm_pkg::ST_DONE: begin
                cmd.out_load = slot_free;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        if ((state_reg == sgpm_pkg::ST_DECAY) || (state_reg == sgpm_pkg::ST_GAIN)) begin
            sel_next = sel_reg + sgpm_pkg::SEL_W'(1);
        end else begin
            sel_next = '0;
        end
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sgpm_pkg::ST_IDLE;
            sel_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sel_reg     <= sel_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

/* design/stereo_gain_pan_ramp_peak_meter_unit.sv */
// Stereo gain and balance stage with a per-block gain ramp and peak meters.
// A request on the s_ channel either sets a new target volume and pan
// (s_func low) or carries one stereo frame (s_func high). Each request gives
// exactly one result on the m_ channel: the gained and saturated samples
// (zero for a target request or a frame without input) and the four held
// positive peaks, input left/right and output left/right.
// A target request goes straight to the output register. A frame passes a
// multiply and an update step; a block's first frame first decays the four
// peaks and forms the four gains, one at a time through one shared multiplier
// each, then runs the restoring divider that forms the ramp step. One request
// is in work at a time; the next is accepted in the cycle after the result is
// loaded into the output register. While a result waits for m_ready, the
// block finishes the work on a request already accepted and then holds it
// until the output register frees. The cfg_ port writes frames_per_block
// (index 0) and peak_decay (index 1) with no wait; the user writes it only
// when the block has no request in work, and the block does not enforce it.
// Synchronous active-low reset restores unity gain, centered pan, a 256-frame
// block, the default decay, cleared meters and an empty output register.
// Depends on sgpm_pkg, sgpm_ctrl, sgpm_dp and sgpm_div.
module stereo_gain_pan_ramp_peak_meter_unit (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    cfg_wr_en,
    input  logic [sgpm_pkg::CFG_ADDR_W-1:0]         cfg_addr,
    input  logic [sgpm_pkg::CFG_DATA_W-1:0]         cfg_wdata,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic                                    s_func,
    input  logic [sgpm_pkg::VOL_W-1:0]              s_volume_gain,
    input  logic signed [sgpm_pkg::PAN_W-1:0]       s_pan,
    input  logic                                    s_input_present,
    input  logic signed [sgpm_pkg::SAMPLE_BITS-1:0] s_sample_left,
    input  logic signed [sgpm_pkg::SAMPLE_BITS-1:0] s_sample_right,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [sgpm_pkg::SAMPLE_BITS-1:0] m_out_left,
    output logic signed [sgpm_pkg::SAMPLE_BITS-1:0] m_out_right,
    output logic [sgpm_pkg::METER_W-1:0]            m_meter_in_left,
    output logic [sgpm_pkg::METER_W-1:0]            m_meter_in_right,
    output logic [sgpm_pkg::METER_W-1:0]            m_meter_out_left,
    output logic [sgpm_pkg::METER_W-1:0]            m_meter_out_right
);

    // The controller sequences each request; the datapath holds all state.
    sgpm_pkg::ctrl_cmd_t cmd;
    sgpm_pkg::dp_stat_t  stat;

    sgpm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_func  (s_func),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    sgpm_dp u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .stat              (stat),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_addr          (cfg_addr),
        .cfg_wdata         (cfg_wdata),
        .s_func            (s_func),
        .s_volume_gain     (s_volume_gain),
        .s_pan             (s_pan),
        .s_input_present   (s_input_present),
        .s_sample_left     (s_sample_left),
        .s_sample_right    (s_sample_right),
        .m_out_left        (m_out_left),
        .m_out_right       (m_out_right),
        .m_meter_in_left   (m_meter_in_left),
        .m_meter_in_right  (m_meter_in_right),
        .m_meter_out_left  (m_meter_out_left),
        .m_meter_out_right (m_meter_out_right)
    );

endmodule

/* design/sgpm_checker.sv */
// Port-level checker for the gain, balance ramp and peak meter block,
// bound to the top level. Uses sgpm_pkg for widths and function codes.
module sgpm_checker (
    input logic                                    aclk,
    input logic                                    aresetn,
    input logic                                    s_valid,
    input logic                                    s_ready,
    input logic                                    s_func,
    input logic                                    m_valid,
    input logic                                    m_ready,
    input logic signed [sgpm_pkg::SAMPLE_BITS-1:0] m_out_left,
    input logic signed [sgpm_pkg::SAMPLE_BITS-1:0] m_out_right
);

    // A held result does not change while the receiver stalls.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_left) && $stable(m_out_right))
        else $error("result changed while stalled");

    // One request in work at a time.
    a_one_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request accepted while one is in work");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A target request with a free output gives a silent result via the done state.
    a_target_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_func == sgpm_pkg::FUNC_SET_TARGET) && (!m_valid || m_ready)
        |=> ##1 m_valid && (m_out_left == '0) && (m_out_right == '0))
        else $error("target request did not give a silent result");

endmodule

bind stereo_gain_pan_ramp_peak_meter_unit sgpm_checker u_sgpm_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_func      (s_func),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_out_left  (m_out_left),
    .m_out_right (m_out_right)
);

/* dv/stereo_gain_pan_ramp_peak_meter_unit_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for stereo_gain_pan_ramp_peak_meter_unit.
// Holds its own predictor of the gain ramp and peak meters; needs sgpm_pkg and the RTL.
module stereo_gain_pan_ramp_peak_meter_unit_tb;
    import sgpm_pkg::*;

    localparam int unsigned CYCLE_LIMIT       = 400000;
    localparam int unsigned LONG_STALL_CYCLES = 400;
    localparam int unsigned REPORT_LIMIT      = 10;
    localparam longint      OUT_HI = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint      OUT_LO = -OUT_HI - 1;

    // One request as offered on the s_ channel.
    typedef struct {
        logic                          func;
        logic [VOL_W-1:0]              volume;
        logic signed [PAN_W-1:0]       pan;
        logic                          present;
        logic signed [SAMPLE_BITS-1:0] left;
        logic signed [SAMPLE_BITS-1:0] right;
    } stereo_req_t;

    // One result as delivered on the m_ channel.
    typedef struct {
        logic signed [SAMPLE_BITS-1:0] out_left;
        logic signed [SAMPLE_BITS-1:0] out_right;
        logic [METER_W-1:0]            pk_in_left;
        logic [METER_W-1:0]            pk_in_right;
        logic [METER_W-1:0]            pk_out_left;
        logic [METER_W-1:0]            pk_out_right;
    } frame_result_t;

    // Every input starts at a known value; the sender and receiver take over at the edges.
    logic                          aclk            = 1'b0;
    logic                          aresetn         = 1'b0;
    logic                          cfg_wr_en       = 1'b0;
    logic [CFG_ADDR_W-1:0]         cfg_addr        = '0;
    logic [CFG_DATA_W-1:0]         cfg_wdata       = '0;
    logic                          s_valid         = 1'b0;
    logic                          s_func          = 1'b0;
    logic [VOL_W-1:0]              s_volume_gain   = '0;
    logic signed [PAN_W-1:0]       s_pan           = '0;
    logic                          s_input_present = 1'b0;
    logic signed [SAMPLE_BITS-1:0] s_sample_left   = '0;
    logic signed [SAMPLE_BITS-1:0] s_sample_right  = '0;
    logic                          m_ready         = 1'b0;
    logic                          s_ready;
    logic                          m_valid;
    logic signed [SAMPLE_BITS-1:0] m_out_left;
    logic signed [SAMPLE_BITS-1:0] m_out_right;
    logic [METER_W-1:0]            m_meter_in_left;
    logic [METER_W-1:0]            m_meter_in_right;
    logic [METER_W-1:0]            m_meter_out_left;
    logic [METER_W-1:0]            m_meter_out_right;

    // Idle percentages of the two sides, and the request for a long receiver hold-off.
    int unsigned src_idle_pct     = 10;
    int unsigned sink_idle_pct    = 70;
    int unsigned stall_token      = 0;
    int unsigned stall_token_seen = 0;
    int unsigned stall_left       = 0;

    int unsigned cycle_count    = 0;
    int unsigned mismatch_count = 0;
    int unsigned results_seen   = 0;

    // Results the predictor has worked out and the block has not yet delivered, oldest first.
    frame_result_t expected_frames[$];

    // Predictor copy of the registers and the block state, at their reset values.
    logic [LEN_W-1:0]        blk_len_cfg = FPB_RESET;
    logic [DECAY_W-1:0]      decay_cfg   = DECAY_RESET;
    logic [VOL_W-1:0]        want_vol    = UNITY_GAIN;
    logic signed [PAN_W-1:0] want_pan    = '0;
    logic [VOL_W-1:0]        held_vol    = UNITY_GAIN;
    logic signed [PAN_W-1:0] held_pan    = '0;
    longint                  ramp_left   = 0;
    longint                  ramp_right  = 0;
    longint                  slope_left  = 0;
    longint                  slope_right = 0;
    int unsigned             frame_pos   = 0;
    logic [METER_W-1:0]      peak_level [NUM_PEAKS] = '{default: '0};

    stereo_gain_pan_ramp_peak_meter_unit uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_addr          (cfg_addr),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_func            (s_func),
        .s_volume_gain     (s_volume_gain),
        .s_pan             (s_pan),
        .s_input_present   (s_input_present),
        .s_sample_left     (s_sample_left),
        .s_sample_right    (s_sample_right),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_out_left        (m_out_left),
        .m_out_right       (m_out_right),
        .m_meter_in_left   (m_meter_in_left),
        .m_meter_in_right  (m_meter_in_right),
        .m_meter_out_left  (m_meter_out_left),
        .m_meter_out_right (m_meter_out_right)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Channel gain after balance: positive pan pulls the left side down, negative pan the
    // right side; the other side keeps the full volume.
    function automatic longint balanced_gain(logic [VOL_W-1:0] vol, logic signed [PAN_W-1:0] pan,
                                             bit right_side);
        longint g;
        g = longint'(vol);
        if (!right_side && pan > 0)
            g = (g * (longint'(PAN_ONE) - longint'(pan))) >>> 15;
        else if (right_side && pan < 0)
            g = (g * (longint'(PAN_ONE) + longint'(pan))) >>> 15;
        return g;
    endfunction

    // Sample times the integer part of the running gain, floored and saturated.
    function automatic longint gained_sample(longint x, longint acc);
        longint p;
        p = (x * (acc >>> ACC_EXTRA)) >>> GAIN_FRAC_BITS;
        if (p > OUT_HI) p = OUT_HI;
        if (p < OUT_LO) p = OUT_LO;
        return p;
    endfunction

    // Per-frame gain increment, truncated toward zero like a signed divide.
    function automatic longint ramp_slope(longint from_gain, longint to_gain, int unsigned len);
        return ((to_gain - from_gain) * (longint'(1) <<< ACC_EXTRA)) / longint'(len);
    endfunction

    function automatic void raise_peak(logic [SEL_W-1:0] slot, longint v);
        if (v > longint'(peak_level[slot]))
            peak_level[slot] = METER_W'(v);
    endfunction

    // Advances the predicted block state by one request and returns the result it gives.
    function automatic frame_result_t gain_stage_step(stereo_req_t req);
        frame_result_t res;
        int unsigned   len;
        longint        decayed, start_l, start_r, xl, xr, ol, orr;
        ol  = 0;
        orr = 0;
        if (req.func == FUNC_SET_TARGET) begin
            want_vol = req.volume;
            want_pan = req.pan;
        end else begin
            len = blk_len_cfg;
            if (len == 0) len = 1;
            if (len > MAX_BLOCK) len = MAX_BLOCK;
            // A shortened block that is already past its new end restarts here.
            if (frame_pos >= len) frame_pos = 0;
            if (frame_pos == 0) begin
                for (int i = 0; i < NUM_PEAKS; i++) begin
                    decayed = (longint'(peak_level[i]) * longint'(decay_cfg)) >>> 16;
                    peak_level[i] = (decayed < PEAK_FLOOR) ? '0 : METER_W'(decayed);
                end
                start_l     = balanced_gain(held_vol, held_pan, 1'b0);
                start_r     = balanced_gain(held_vol, held_pan, 1'b1);
                ramp_left   = start_l <<< ACC_EXTRA;
                ramp_right  = start_r <<< ACC_EXTRA;
                slope_left  = ramp_slope(start_l, balanced_gain(want_vol, want_pan, 1'b0), len);
                slope_right = ramp_slope(start_r, balanced_gain(want_vol, want_pan, 1'b1), len);
                held_vol    = want_vol;
                held_pan    = want_pan;
            end
            if (req.present) begin
                xl  = longint'(req.left);
                xr  = longint'(req.right);
                ol  = gained_sample(xl, ramp_left);
                orr = gained_sample(xr, ramp_right);
                raise_peak(PK_IN_L, xl);
                raise_peak(PK_IN_R, xr);
                raise_peak(PK_OUT_L, ol);
                raise_peak(PK_OUT_R, orr);
            end
            // The ramp moves on even for a silent frame and never goes below zero gain.
            ramp_left  += slope_left;
            ramp_right += slope_right;
            if (ramp_left < 0) ramp_left = 0;
            if (ramp_right < 0) ramp_right = 0;
            frame_pos++;
            if (frame_pos >= len) frame_pos = 0;
        end
        res.out_left     = SAMPLE_BITS'(ol);
        res.out_right    = SAMPLE_BITS'(orr);
        res.pk_in_left   = peak_level[PK_IN_L];
        res.pk_in_right  = peak_level[PK_IN_R];
        res.pk_out_left  = peak_level[PK_OUT_L];
        res.pk_out_right = peak_level[PK_OUT_R];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Request builders
    // ------------------------------------------------------------------

    // A target request; the sample fields are ignored by the block and carry noise.
    function automatic stereo_req_t target_req(int unsigned vol, int pan);
        stereo_req_t r;
        r.func    = FUNC_SET_TARGET;
        r.volume  = VOL_W'(vol);
        r.pan     = PAN_W'(pan);
        r.present = 1'($urandom);
        r.left    = SAMPLE_BITS'($urandom);
        r.right   = SAMPLE_BITS'($urandom);
        return r;
    endfunction

    // A frame request; volume and pan are ignored and carry noise.
    function automatic stereo_req_t frame_req(bit present, int left, int right);
        stereo_req_t r;
        r.func    = FUNC_FRAME;
        r.volume  = VOL_W'($urandom);
        r.pan     = PAN_W'($urandom);
        r.present = present;
        r.left    = SAMPLE_BITS'(left);
        r.right   = SAMPLE_BITS'(right);
        return r;
    endfunction

    function automatic int random_sample();
        case ($urandom_range(7))
            0:       return int'(OUT_HI);
            1:       return int'(OUT_LO);
            2:       return $urandom_range(0, 64) - 32;
            default: return int'(SAMPLE_BITS'($urandom));
        endcase
    endfunction

    // Mostly frames with audio; target changes come often enough to keep the ramp moving.
    function automatic stereo_req_t random_request();
        int unsigned vol;
        if ($urandom_range(99) < 12) begin
            case ($urandom_range(3))
                0:       vol = UNITY_GAIN;
                1:       vol = $urandom_range(0, 2 * UNITY_GAIN);
                default: vol = $urandom;
            endcase
            return target_req(vol, ($urandom_range(4) == 0) ? 0 : int'($urandom));
        end
        return frame_req($urandom_range(9) != 0, random_sample(), random_sample());
    endfunction

    // ------------------------------------------------------------------
    // Sender, configuration and receiver
    // ------------------------------------------------------------------

    // Offers one request, holds it until the block takes it, then records what it should give.
    // Valid is left high afterwards so that back-to-back requests need no second assignment.
    task automatic send_request(input stereo_req_t req);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_func          <= req.func;
        s_volume_gain   <= req.volume;
        s_pan           <= req.pan;
        s_input_present <= req.present;
        s_sample_left   <= req.left;
        s_sample_right  <= req.right;
        do @(posedge aclk); while (!s_ready);
        expected_frames.push_back(gain_stage_step(req));
    endtask

    // Drops valid and waits until the block has handed back every result it owes.
    // Every request gives a result, so an empty queue means no work is left behind.
    task automatic drain_block();
        s_valid <= 1'b0;
        while (expected_frames.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_ADDR_W-1:0] idx, input int unsigned value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= CFG_DATA_W'(value);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        if (idx == CFG_FRAMES_PER_BLOCK)
            blk_len_cfg = LEN_W'(value);
        else
            decay_cfg = DECAY_W'(value);
    endtask

    task automatic set_idling(input int unsigned src_pct, input int unsigned sink_pct);
        src_idle_pct  <= src_pct;
        sink_idle_pct <= sink_pct;
    endtask

    // The receiver counts out a long hold-off on its own whenever the token moves;
    // otherwise it drops ready at random according to the current idle percentage.
    always @(posedge aclk) begin
        if (stall_token != stall_token_seen) begin
            stall_token_seen <= stall_token;
            stall_left       <= LONG_STALL_CYCLES;
            m_ready          <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic log_mismatch(input string what, input longint want, input longint got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("result %0d: %s expected %0d, got %0d", results_seen, what, want, got);
    endtask

    task automatic compare_field(input string what, input longint want, input longint got);
        if (want != got)
            log_mismatch(what, want, got);
    endtask

    // Inputs all change on nonblocking assignments, so the values read here are the ones
    // that stood before the edge: a handshake seen here really took place at this edge.
    always @(posedge aclk) begin : result_check
        frame_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_frames.size() == 0) begin
                log_mismatch("result with nothing outstanding, out_left", 0, m_out_left);
            end else begin
                want = expected_frames.pop_front();
                compare_field("out_left", want.out_left, m_out_left);
                compare_field("out_right", want.out_right, m_out_right);
                compare_field("meter_in_left", want.pk_in_left, m_meter_in_left);
                compare_field("meter_in_right", want.pk_in_right, m_meter_in_right);
                compare_field("meter_out_left", want.pk_out_left, m_meter_out_left);
                compare_field("meter_out_right", want.pk_out_right, m_meter_out_right);
            end
            results_seen++;
        end
    end

    // A hung handshake ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic apply_reset();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
    endtask

    // Reset configuration: unity gain over a 256-frame block. Full-scale samples of both
    // signs, a silent frame carrying loud samples, and a target request mid-block.
    task automatic test_unity_frames();
        send_request(frame_req(1'b1, int'(OUT_HI), int'(OUT_LO)));
        send_request(frame_req(1'b1, int'(OUT_LO), int'(OUT_HI)));
        send_request(frame_req(1'b0, int'(OUT_HI), int'(OUT_HI)));
        send_request(target_req(UNITY_GAIN, 0));
        send_request(frame_req(1'b1, -1, 1));
    endtask

    // A zero block length acts as one frame, so every frame opens a block and the new
    // target shows one frame later. Maximum volume saturates; full pan mutes one side.
    task automatic test_full_scale_balance();
        drain_block();
        write_register(CFG_FRAMES_PER_BLOCK, 0);
        write_register(CFG_PEAK_DECAY, 65535);
        send_request(target_req((1 << VOL_W) - 1, -32768));
        send_request(frame_req(1'b1, int'(OUT_HI), int'(OUT_HI)));
        send_request(frame_req(1'b1, int'(OUT_HI), int'(OUT_HI)));
        send_request(frame_req(1'b1, int'(OUT_LO), int'(OUT_HI)));
        send_request(target_req((1 << VOL_W) - 1, 32767));
        send_request(frame_req(1'b1, int'(OUT_LO), int'(OUT_LO)));
        send_request(frame_req(1'b1, int'(OUT_HI), int'(OUT_LO)));
        send_request(target_req(0, 0));
        send_request(frame_req(1'b1, 4194304, -4194304));
    endtask

    // Length changes inside a block: shortening below the current position restarts the
    // block, and growing a falling ramp lets the gain run past zero where it is clamped.
    // An over-range length is saturated to the largest block.
    task automatic test_block_resize();
        drain_block();
        write_register(CFG_FRAMES_PER_BLOCK, 5);
        send_request(target_req(200000, 16384));
        send_request(frame_req(1'b1, 3000000, 3000000));
        send_request(frame_req(1'b1, -3000000, 3000000));
        send_request(frame_req(1'b1, 3000000, -3000000));
        drain_block();
        write_register(CFG_FRAMES_PER_BLOCK, 2);
        send_request(frame_req(1'b1, 5000000, 5000000));
        send_request(frame_req(1'b1, 5000000, 5000000));
        send_request(target_req(0, -16384));
        send_request(frame_req(1'b1, 6000000, 6000000));
        drain_block();
        write_register(CFG_FRAMES_PER_BLOCK, (1 << LEN_W) - 1);
        send_request(frame_req(1'b1, 6000000, 6000000));
        send_request(frame_req(1'b1, 6000000, 6000000));
    endtask

    // Peak decay extremes and the floor: a zero factor clears the meters, and with the
    // largest factor a peak of nine decays below the floor while ten stays at nine.
    task automatic test_peak_floor();
        drain_block();
        write_register(CFG_FRAMES_PER_BLOCK, 1);
        write_register(CFG_PEAK_DECAY, 0);
        send_request(frame_req(1'b0, 0, 0));
        drain_block();
        write_register(CFG_PEAK_DECAY, 65535);
        send_request(frame_req(1'b1, 9, 10));
        send_request(frame_req(1'b0, 0, 0));
        send_request(frame_req(1'b0, 0, 0));
    endtask

    task automatic pick_random_config();
        int unsigned len;
        int unsigned decay;
        case ($urandom_range(7))
            0:       len = 0;
            1:       len = 1;
            2:       len = MAX_BLOCK;
            3:       len = (1 << LEN_W) - 1;
            4, 5:    len = $urandom_range(2, 12);
            6:       len = $urandom_range(13, 64);
            default: len = $urandom_range(65, (1 << LEN_W) - 1);
        endcase
        case ($urandom_range(3))
            0:       decay = 0;
            1:       decay = (1 << DECAY_W) - 1;
            default: decay = $urandom_range(0, (1 << DECAY_W) - 1);
        endcase
        write_register(CFG_FRAMES_PER_BLOCK, len);
        write_register(CFG_PEAK_DECAY, decay);
    endtask

    // Random traffic in chunks, each under its own register setting. The chunks walk through
    // the three idling patterns: slow receiver, then slow sender, then both at full rate.
    task automatic test_random_traffic();
        for (int chunk = 0; chunk < 10; chunk++) begin
            drain_block();
            if (chunk == 4)
                set_idling(70, 10);
            else if (chunk == 7)
                set_idling(0, 0);
            pick_random_config();
            repeat (55) send_request(random_request());
        end
    endtask

    // The receiver holds off for a long stretch while requests keep coming, so the output
    // register and the request in work both fill and the block has to stall its input.
    task automatic test_output_backpressure();
        drain_block();
        write_register(CFG_FRAMES_PER_BLOCK, $urandom_range(1, 8));
        stall_token <= stall_token + 1;
        repeat (30) send_request(frame_req(1'b1, random_sample(), random_sample()));
    endtask

    initial begin
        apply_reset();
        test_unity_frames();
        test_full_scale_balance();
        test_block_resize();
        test_peak_floor();
        test_random_traffic();
        test_output_backpressure();

        // Let the last results come back, then check that none is still owed.
        drain_block();
        repeat (60) @(posedge aclk);
        if (expected_frames.size() != 0)
            log_mismatch("results never delivered, count", 0, expected_frames.size());
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* filelist.f */
design/sgpm_pkg.sv
design/sgpm_div.sv
design/sgpm_dp.sv
design/sgpm_ctrl.sv
design/stereo_gain_pan_ramp_peak_meter_unit.sv
design/sgpm_checker.sv
dv/stereo_gain_pan_ramp_peak_meter_unit_tb.sv
